FILE: hdl/bamd_pkg.sv
// ----------------------------------------------------------------------------
// bamd_pkg
// Shared types, opcodes and the gamma-and-scale table builder for the
// bit angle modulation LED dimmer.
// ----------------------------------------------------------------------------
package bamd_pkg;

    // Default configuration of the dimmer.
    localparam int BAMD_NUM_LEDS   = 12;
    localparam int BAMD_MOD_BITS   = 6;
    localparam int BAMD_DITHER_LOG = 2;

    // Fixed field widths of the transaction payloads.
    localparam int MASK_W  = 12;
    localparam int INDEX_W = 4;
    localparam int CMD_W   = 8;

    // Gamma table geometry.
    localparam int GAMMA_MAX = 255;
    localparam int ROM_DEPTH = 256;
    localparam int ROM_W     = 16;
    localparam int BIG_W     = 144;

    typedef enum logic [1:0] {
        OP_TICK   = 2'd0,
        OP_LOAD   = 2'd1,
        OP_COMMIT = 2'd2
    } op_t;

    typedef struct packed {
        logic [1:0]         op;
        logic [INDEX_W-1:0] led_index;
        logic [CMD_W-1:0]   duty_command;
    } bamd_in_t;

    typedef struct packed {
        logic [MASK_W-1:0] led_on_mask;
        logic              commit_accepted;
        logic              tables_swapped;
    } bamd_out_t;

    typedef logic [ROM_DEPTH-1:0][ROM_W-1:0] scale_rom_t;

    // Builds the combined gamma-2.2 and scaling table at elaboration.
    // The gamma value d for command c is the largest d with
    // c^11 * 510^5 >= (2d-1)^5 * 255^11, which is 255*(c/255)^2.2 rounded
    // half up. Gamma is monotonic in c, so the search resumes from the
    // previous entry. The scaled duty is (g*S + 127) / 255.
    function automatic scale_rom_t build_scale_rom(input int mod_bits, input int dither_log);
        scale_rom_t       rom;
        logic [BIG_W-1:0] k510;
        logic [BIG_W-1:0] k255;
        logic [BIG_W-1:0] lhs;
        logic [BIG_W-1:0] rhs;
        logic [BIG_W-1:0] odd;
        logic             more;
        int               d;
        int               scale;
        k510 = BIG_W'(1);
        k255 = BIG_W'(1);
        for (int k = 0; k < 5; k++)
        begin
            k510 = k510 * BIG_W'(510);
        end
        for (int k = 0; k < 11; k++)
        begin
            k255 = k255 * BIG_W'(GAMMA_MAX);
        end
        scale = ((1 << mod_bits) - 1) * (1 << dither_log);
        d = 0;
        for (int c = 0; c < ROM_DEPTH; c++)
        begin
            lhs = k510;
            for (int k = 0; k < 11; k++)
            begin
                lhs = lhs * BIG_W'(c);
            end
            more = 1'b1;
            while (more && (d < GAMMA_MAX))
            begin
                odd = BIG_W'(2 * d + 1);
                rhs = k255;
                for (int k = 0; k < 5; k++)
                begin
                    rhs = rhs * odd;
                end
                if (lhs >= rhs)
                begin
                    d = d + 1;
                end
                else
                begin
                    more = 1'b0;
                end
            end
            rom[c] = ROM_W'((d * scale + 127) / GAMMA_MAX);
        end
        return rom;
    endfunction

endpackage

FILE: hdl/bamd_in_stage.sv
// ----------------------------------------------------------------------------
// bamd_in_stage
// Input register of the dimmer: captures one command transaction and holds
// it until the engine has moved its result into the output register.
// ----------------------------------------------------------------------------
module bamd_in_stage
    import bamd_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     cmd_valid,
    output logic     cmd_ready,
    input  bamd_in_t cmd_data,
    input  logic     advance,
    output logic     item_valid,
    output bamd_in_t item
);

    logic     valid_reg;
    bamd_in_t item_reg;

    // The stage takes a new transaction when empty or when its current one moves on.
    assign cmd_ready  = !valid_reg || advance;
    assign item_valid = valid_reg;
    assign item       = item_reg;

    // Valid flag of the stage.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (cmd_valid && cmd_ready)
        begin
            valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            valid_reg <= 1'b0;
        end
    end

    // Payload capture.
    always_ff @(posedge clk)
    begin
        if (cmd_valid && cmd_ready)
        begin
            item_reg <= cmd_data;
        end
    end

endmodule

FILE: hdl/bamd_engine.sv
// ----------------------------------------------------------------------------
// bamd_engine
// Dimmer state and the combinational work for one command: staging writes,
// table commit through the gamma table, and the per-tick on-mask with the
// bit, tick and dither phase counters.
// ----------------------------------------------------------------------------
module bamd_engine
    import bamd_pkg::*;
#(
    parameter int NUM_LEDS   = BAMD_NUM_LEDS,
    parameter int MOD_BITS   = BAMD_MOD_BITS,
    parameter int DITHER_LOG = BAMD_DITHER_LOG
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      step,
    input  bamd_in_t  item,
    output bamd_out_t result
);

    localparam int DUTY_W  = MOD_BITS + DITHER_LOG;
    localparam int BIT_W   = $clog2(MOD_BITS);
    localparam int PHASE_W = (DITHER_LOG > 0) ? DITHER_LOG : 1;
    localparam int WIDE_W  = (NUM_LEDS > MASK_W) ? NUM_LEDS : MASK_W;

    localparam logic [BIT_W-1:0]    LAST_BIT   = BIT_W'(MOD_BITS - 1);
    localparam logic [MOD_BITS-1:0] LEVEL_MAX  = MOD_BITS'((1 << MOD_BITS) - 1);
    localparam logic [PHASE_W-1:0]  FRAC_MASK  = PHASE_W'((1 << DITHER_LOG) - 1);
    localparam scale_rom_t          SCALE_ROM  = build_scale_rom(MOD_BITS, DITHER_LOG);

    logic [CMD_W-1:0]    staged_reg [NUM_LEDS];
    logic [DUTY_W-1:0]   front_reg  [NUM_LEDS];
    logic [DUTY_W-1:0]   back_reg   [NUM_LEDS];
    logic [DUTY_W-1:0]   rom_out    [NUM_LEDS];
    logic                swap_pending_reg;
    logic                swap_pending_next;
    logic [BIT_W-1:0]    bit_pos_reg;
    logic [BIT_W-1:0]    bit_pos_next;
    logic [PHASE_W-1:0]  phase_reg;
    logic [PHASE_W-1:0]  phase_next;
    logic [MOD_BITS-1:0] ticks_reg;
    logic [MOD_BITS-1:0] ticks_next;
    logic [MOD_BITS-1:0] ticks_load;
    logic                is_tick;
    logic                is_load;
    logic                is_commit;
    logic                commit_take;
    logic                bit_done;
    logic                frame_end;
    logic                do_swap;
    logic [NUM_LEDS-1:0] on_vec;
    logic [WIDE_W-1:0]   on_wide;

    // Level of one LED in the current dither phase, tested at the current bit.
    function automatic logic led_on(
        input logic [DUTY_W-1:0]  duty,
        input logic [PHASE_W-1:0] phase,
        input logic [BIT_W-1:0]   bp
    );
        logic [MOD_BITS-1:0] base;
        logic [PHASE_W-1:0]  frac;
        logic [MOD_BITS-1:0] level;
        base  = MOD_BITS'(duty >> DITHER_LOG);
        frac  = PHASE_W'(duty) & FRAC_MASK;
        level = base;
        if ((base != LEVEL_MAX) && (phase < frac))
        begin
            level = base + MOD_BITS'(1);
        end
        return level[bp];
    endfunction

    // Operation decoder.
    always_comb
    begin
        is_tick   = 1'b0;
        is_load   = 1'b0;
        is_commit = 1'b0;
        unique case (item.op)
            OP_TICK:   is_tick   = 1'b1;
            OP_LOAD:   is_load   = 1'b1;
            OP_COMMIT: is_commit = 1'b1;
            default:   ;
        endcase
    end

    assign commit_take = is_commit && !swap_pending_reg;

    // Gamma and scale lookup for every staged command.
    always_comb
    begin
        for (int i = 0; i < NUM_LEDS; i++)
        begin
            rom_out[i] = DUTY_W'(SCALE_ROM[staged_reg[i]]);
        end
    end

    // On-mask of all LEDs from the front table.
    always_comb
    begin
        for (int i = 0; i < NUM_LEDS; i++)
        begin
            on_vec[i] = led_on(front_reg[i], phase_reg, bit_pos_reg);
        end
        on_wide = WIDE_W'(on_vec);
    end

    // Tick counter, bit position and frame end.
    always_comb
    begin
        ticks_load = (ticks_reg == '0) ? (MOD_BITS'(1) << bit_pos_reg) : ticks_reg;
        ticks_next = ticks_load - MOD_BITS'(1);
        bit_done   = (ticks_next == '0);
        frame_end  = bit_done && (bit_pos_reg == LAST_BIT);
        do_swap    = frame_end && swap_pending_reg;
    end

    // Next values of the scalar control state.
    always_comb
    begin
        swap_pending_next = swap_pending_reg;
        bit_pos_next      = bit_pos_reg;
        phase_next        = phase_reg;
        if (is_commit && !swap_pending_reg)
        begin
            swap_pending_next = 1'b1;
        end
        if (is_tick && bit_done)
        begin
            bit_pos_next = frame_end ? '0 : bit_pos_reg + BIT_W'(1);
        end
        if (is_tick && frame_end)
        begin
            if (do_swap)
            begin
                swap_pending_next = 1'b0;
                phase_next        = '0;
            end
            else if (DITHER_LOG == 0)
            begin
                phase_next = '0;
            end
            else
            begin
                phase_next = phase_reg + PHASE_W'(1);
            end
        end
    end

    // Result of the current transaction.
    always_comb
    begin
        result.led_on_mask     = is_tick ? on_wide[MASK_W-1:0] : '0;
        result.commit_accepted = commit_take;
        result.tables_swapped  = is_tick && do_swap;
    end

    // Control counters.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            swap_pending_reg <= 1'b0;
            bit_pos_reg      <= '0;
            phase_reg        <= '0;
            ticks_reg        <= '0;
        end
        else if (step)
        begin
            swap_pending_reg <= swap_pending_next;
            bit_pos_reg      <= bit_pos_next;
            phase_reg        <= phase_next;
            if (is_tick)
            begin
                ticks_reg <= ticks_next;
            end
        end
    end

    // Staging, back and front duty tables.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_LEDS; i++)
            begin
                staged_reg[i] <= '0;
                front_reg[i]  <= '0;
                back_reg[i]   <= '0;
            end
        end
        else if (step)
        begin
            for (int i = 0; i < NUM_LEDS; i++)
            begin
                if (is_load && (32'(item.led_index) == i))
                begin
                    staged_reg[i] <= item.duty_command;
                end
                if (commit_take)
                begin
                    back_reg[i] <= rom_out[i];
                end
                if (is_tick && do_swap)
                begin
                    front_reg[i] <= back_reg[i];
                    back_reg[i]  <= front_reg[i];
                end
            end
        end
    end

endmodule

FILE: hdl/bam_led_dimmer_with_dither_top.sv
// ----------------------------------------------------------------------------
// bam_led_dimmer_with_dither_top
// Bit angle modulation LED dimmer with gamma correction and temporal dither.
// ----------------------------------------------------------------------------
// Usage:
// The command channel (cmd_valid, cmd_ready, cmd_data) carries three kinds
// of transaction: a tick, a load of one LED command into staging, and a
// commit that maps all staged commands through the gamma table into the
// back duty table. Every command gives exactly one result transaction on
// the result channel (res_valid, res_ready, res_data): the on-mask for a
// tick, and the commit-accepted and tables-swapped flags.
// A command waits in the input register; the compare and counter logic
// then writes its result into the output register, where res_valid rises.
// Throughput is one command per cycle while the receiver takes results;
// the counters and the twelve level compares update once per command.
// When the receiver stalls, the result is held and one further command can
// wait in the input register; cmd_ready drops only when both are full.
// Reset clears the staging and duty tables (all LEDs off), the swap flag
// and the bit, tick and dither phase counters.
// ----------------------------------------------------------------------------
module bam_led_dimmer_with_dither_top
    import bamd_pkg::*;
#(
    parameter int NUM_LEDS   = BAMD_NUM_LEDS,
    parameter int MOD_BITS   = BAMD_MOD_BITS,
    parameter int DITHER_LOG = BAMD_DITHER_LOG
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      cmd_valid,
    output logic      cmd_ready,
    input  bamd_in_t  cmd_data,
    output logic      res_valid,
    input  logic      res_ready,
    output bamd_out_t res_data
);

    logic      item_valid;
    logic      advance;
    bamd_in_t  item;
    bamd_out_t result;
    logic      res_valid_reg;
    bamd_out_t res_data_reg;

    // The held command moves on when the output register is free or being emptied.
    assign advance = item_valid && (!res_valid_reg || res_ready);

    bamd_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd_valid  (cmd_valid),
        .cmd_ready  (cmd_ready),
        .cmd_data   (cmd_data),
        .advance    (advance),
        .item_valid (item_valid),
        .item       (item)
    );

    bamd_engine #(
        .NUM_LEDS   (NUM_LEDS),
        .MOD_BITS   (MOD_BITS),
        .DITHER_LOG (DITHER_LOG)
    ) u_engine (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (advance),
        .item   (item),
        .result (result)
    );

    // Output register valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            res_valid_reg <= 1'b1;
        end
        else if (res_ready)
        begin
            res_valid_reg <= 1'b0;
        end
    end

    // Output register payload.
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            res_data_reg <= result;
        end
    end

    assign res_valid = res_valid_reg;
    assign res_data  = res_data_reg;

endmodule

FILE: hdl/bamd_checker.sv
// ----------------------------------------------------------------------------
// bamd_checker
// Port-level checks for the dimmer, bound to the top level.
// ----------------------------------------------------------------------------
module bamd_checker
    import bamd_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      cmd_valid,
    input logic      cmd_ready,
    input logic      res_valid,
    input logic      res_ready,
    input bamd_out_t res_data
);

    // A stalled result stays valid and unchanged.
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(res_data))
        else $error("result changed or dropped while stalled");

    // With the output register empty the block always takes a command.
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !res_valid |-> cmd_ready)
        else $error("command refused while no result is waiting");

    // A commit result carries no mask and no swap.
    a_commit_alone: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_data.commit_accepted |->
            (res_data.led_on_mask == '0) && !res_data.tables_swapped)
        else $error("commit result mixed with tick flags");

    // A transaction accepted into an empty block moves on into a valid result.
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && cmd_ready && !res_valid ##1 !res_valid |=> res_valid)
        else $error("result missing two cycles after acceptance");

endmodule

bind bam_led_dimmer_with_dither_top bamd_checker u_bamd_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res_data  (res_data)
);

FILE: verif/bam_led_dimmer_with_dither_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bam_led_dimmer_with_dither_top_tb
// Self-checking testbench for the bit angle modulation LED dimmer. A short
// table of directed commands (reset state, extreme loads, ignored loads,
// commits while a swap is due, whole frames and a full dither cycle) is
// followed by random traffic that is mostly ticks with loads and commits
// mixed in. Every accepted command is run through a behavioural model of
// the dimmer, and each result transaction is compared field by field with
// the oldest outstanding prediction. Both channels idle in random bursts,
// the result side holds off once for a long stretch, and the command side
// pauses once until all results have drained.
// ----------------------------------------------------------------------------
module bam_led_dimmer_with_dither_top_tb;
    import bamd_pkg::*;

    localparam int        LEVEL_TOP  = (1 << BAMD_MOD_BITS) - 1;
    localparam int        PHASES     = 1 << BAMD_DITHER_LOG;
    localparam int        DUTY_SCALE = LEVEL_TOP * PHASES;
    localparam logic [1:0] OP_SPARE  = 2'd3;
    localparam int        BIG_W_TB   = 160;
    localparam int        HOLD_LEN   = 60;
    localparam int        RANDOM_ITEMS = 200;
    localparam int        IN_W       = $bits(bamd_in_t);

    typedef struct {
        bamd_in_t  item;
        int        count;
        bit        typed;
        bamd_out_t want;
    } stim_row_t;

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      cmd_valid = 1'b0;
    logic      cmd_ready;
    bamd_in_t  cmd_data  = '0;
    logic      res_valid;
    logic      res_ready = 1'b0;
    bamd_out_t res_data;

    // Behavioural copy of the dimmer state.
    logic [7:0]                  duty_lut [ROM_DEPTH];
    logic [7:0]                  staged_cmd [BAMD_NUM_LEDS];
    logic [7:0]                  front_duty [BAMD_NUM_LEDS];
    logic [7:0]                  back_duty [BAMD_NUM_LEDS];
    logic                        swap_due;
    logic [2:0]                  bit_pos;
    logic [BAMD_DITHER_LOG-1:0]  dither_ph;
    logic [5:0]                  ticks_left;

    bamd_out_t pending_results[$];
    stim_row_t stim_table[$];
    int        err_count = 0;
    int        idle_rate = 0;
    bit        hold_req  = 1'b0;

    bam_led_dimmer_with_dither_top u_dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd_data  (cmd_data),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res_data  (res_data)
    );

    // 100 MHz clock.
    always #5 clk = ~clk;

    // Gamma 2.2 with half-up rounding, found by a binary search on the
    // exact integer form c^11 * 510^5 >= (2d-1)^5 * 255^11.
    function automatic logic [7:0] gamma_of(input int c);
        logic [BIG_W_TB-1:0] num;
        logic [BIG_W_TB-1:0] den;
        logic [BIG_W_TB-1:0] pow255;
        int                  lo;
        int                  hi;
        int                  mid;
        num    = BIG_W_TB'(1);
        pow255 = BIG_W_TB'(1);
        for (int k = 0; k < 11; k++)
        begin
            num    = num * BIG_W_TB'(c);
            pow255 = pow255 * BIG_W_TB'(GAMMA_MAX);
        end
        for (int k = 0; k < 5; k++)
        begin
            num = num * BIG_W_TB'(510);
        end
        lo = 0;
        hi = GAMMA_MAX;
        while (lo < hi)
        begin
            mid = (lo + hi + 1) / 2;
            den = pow255;
            for (int k = 0; k < 5; k++)
            begin
                den = den * BIG_W_TB'(2 * mid - 1);
            end
            if (num >= den)
            begin
                lo = mid;
            end
            else
            begin
                hi = mid - 1;
            end
        end
        return 8'(lo);
    endfunction

    // Brightness level of one LED in the given dither phase.
    function automatic int led_level(input logic [7:0] duty, input int phase);
        int base;
        int frac;
        int lvl;
        base = duty >> BAMD_DITHER_LOG;
        frac = duty & (PHASES - 1);
        lvl  = base;
        if (base < LEVEL_TOP && phase < frac)
        begin
            lvl = base + 1;
        end
        if (lvl > LEVEL_TOP)
        begin
            lvl = LEVEL_TOP;
        end
        return lvl;
    endfunction

    // Applies one command to the model state and returns its result.
    function automatic bamd_out_t dimmer_response(input bamd_in_t item);
        bamd_out_t  res;
        int         bp;
        logic [7:0] tmp;
        res = '0;
        case (item.op)
            OP_LOAD:
            begin
                if (item.led_index < BAMD_NUM_LEDS)
                begin
                    staged_cmd[item.led_index] = item.duty_command;
                end
            end
            OP_COMMIT:
            begin
                if (!swap_due)
                begin
                    for (int i = 0; i < BAMD_NUM_LEDS; i++)
                    begin
                        back_duty[i] = duty_lut[staged_cmd[i]];
                    end
                    swap_due            = 1'b1;
                    res.commit_accepted = 1'b1;
                end
            end
            OP_TICK:
            begin
                bp = bit_pos;
                if (ticks_left == 0)
                begin
                    ticks_left = 6'(1 << bp);
                end
                for (int i = 0; i < BAMD_NUM_LEDS && i < MASK_W; i++)
                begin
                    if ((led_level(front_duty[i], dither_ph) >> bp) & 1)
                    begin
                        res.led_on_mask[i] = 1'b1;
                    end
                end
                ticks_left = ticks_left - 6'd1;
                if (ticks_left == 0)
                begin
                    bp = bp + 1;
                    if (bp >= BAMD_MOD_BITS)
                    begin
                        bp        = 0;
                        dither_ph = dither_ph + 1'b1;
                        if (swap_due)
                        begin
                            for (int i = 0; i < BAMD_NUM_LEDS; i++)
                            begin
                                tmp           = front_duty[i];
                                front_duty[i] = back_duty[i];
                                back_duty[i]  = tmp;
                            end
                            swap_due           = 1'b0;
                            dither_ph          = '0;
                            res.tables_swapped = 1'b1;
                        end
                    end
                end
                bit_pos = 3'(bp);
            end
            default:
            begin
            end
        endcase
        return res;
    endfunction

    // One line per mismatch, and a running count.
    task automatic report_mismatch(input string what, input int got, input int want);
        $display("%0t mismatch: %s got %0h expected %0h", $realtime, what, got, want);
        err_count++;
    endtask

    task automatic add_row(input logic [1:0] op, input int idx, input int cmd, input int count,
                           input bit typed, input int mask, input bit acc, input bit swp);
        stim_row_t row;
        row.item.op                 = op;
        row.item.led_index          = INDEX_W'(idx);
        row.item.duty_command       = CMD_W'(cmd);
        row.count                   = count;
        row.typed                   = typed;
        row.want.led_on_mask        = MASK_W'(mask);
        row.want.commit_accepted    = acc;
        row.want.tables_swapped     = swp;
        stim_table.push_back(row);
    endtask

    // Offers one command, optionally after an idle burst, and records the
    // expected result once the transaction has been accepted.
    task automatic drive_item(input bamd_in_t item, input bit typed, input bamd_out_t want);
        bamd_out_t model_res;
        int        gap;
        if (idle_rate != 0 && $urandom_range(0, 15) < idle_rate)
        begin
            gap = $urandom_range(1, 16);
            cmd_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        cmd_valid <= 1'b1;
        cmd_data  <= item;
        do
        begin
            @(posedge clk);
        end
        while (!cmd_ready);
        model_res = dimmer_response(item);
        pending_results.push_back(typed ? want : model_res);
        @(negedge clk);
    endtask

    // Random command, weighted towards ticks so that frames complete.
    function automatic bamd_in_t random_item();
        bamd_in_t item;
        int       pick;
        item = bamd_in_t'(IN_W'($urandom));
        pick = $urandom_range(0, 99);
        if (pick < 78)
        begin
            item.op = OP_TICK;
        end
        else if (pick < 92)
        begin
            item.op = OP_LOAD;
            if ($urandom_range(0, 9) == 0)
            begin
                item.led_index = INDEX_W'($urandom_range(BAMD_NUM_LEDS, 15));
            end
            else
            begin
                item.led_index = INDEX_W'($urandom_range(0, BAMD_NUM_LEDS - 1));
            end
            case ($urandom_range(0, 7))
                0:       item.duty_command = '0;
                1:       item.duty_command = '1;
                default: item.duty_command = CMD_W'($urandom);
            endcase
        end
        else if (pick < 98)
        begin
            item.op = OP_COMMIT;
        end
        else
        begin
            item.op = OP_SPARE;
        end
        return item;
    endfunction

    // Result checker: every accepted result against the oldest prediction.
    always @(posedge clk)
    begin
        bamd_out_t want;
        if (rst_n && res_valid && res_ready)
        begin
            if (pending_results.size() == 0)
            begin
                report_mismatch("unexpected result, mask", res_data.led_on_mask, 0);
            end
            else
            begin
                want = pending_results.pop_front();
                if (res_data.led_on_mask !== want.led_on_mask)
                begin
                    report_mismatch("led_on_mask", res_data.led_on_mask, want.led_on_mask);
                end
                if (res_data.commit_accepted !== want.commit_accepted)
                begin
                    report_mismatch("commit_accepted", res_data.commit_accepted,
                                    want.commit_accepted);
                end
                if (res_data.tables_swapped !== want.tables_swapped)
                begin
                    report_mismatch("tables_swapped", res_data.tables_swapped,
                                    want.tables_swapped);
                end
            end
        end
    end

    // Result side: random stall bursts, plus one long hold-off on request.
    initial
    begin
        int hold_cycles;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                res_ready <= 1'b0;
                hold_cycles = 0;
                while (hold_cycles < HOLD_LEN)
                begin
                    @(negedge clk);
                    hold_cycles++;
                end
                hold_req = 1'b0;
            end
            else if (idle_rate != 0 && $urandom_range(0, 15) < idle_rate)
            begin
                res_ready <= 1'b0;
                repeat ($urandom_range(0, 15)) @(negedge clk);
            end
            else
            begin
                res_ready <= 1'b1;
            end
        end
    end

    // Run limit.
    initial
    begin
        #5_000_000;
        $display("tb: failure");
        $finish;
    end

    // Main sequence.
    initial
    begin
        bamd_in_t item;
        bamd_out_t none;
        int       done_items;
        bit       hold_done;
        bit       pause_done;

        none       = '0;
        done_items = 0;
        hold_done  = 1'b0;
        pause_done = 1'b0;

        // Model state after reset, and the gamma-and-scale lookup.
        for (int c = 0; c < ROM_DEPTH; c++)
        begin
            duty_lut[c] = 8'((int'(gamma_of(c)) * DUTY_SCALE + 127) / GAMMA_MAX);
        end
        for (int i = 0; i < BAMD_NUM_LEDS; i++)
        begin
            staged_cmd[i] = '0;
            front_duty[i] = '0;
            back_duty[i]  = '0;
        end
        swap_due   = 1'b0;
        bit_pos    = '0;
        dither_ph  = '0;
        ticks_left = '0;

        // Directed table: op, index, command, repeat count, typed result.
        add_row(OP_TICK,   0,  0,    1,   1, 0, 0, 0);   // all LEDs off after reset
        add_row(OP_SPARE,  15, 8'hFF, 1,  1, 0, 0, 0);   // unused opcode does nothing
        add_row(OP_LOAD,   0,  255,  1,   1, 0, 0, 0);
        add_row(OP_LOAD,   1,  128,  1,   1, 0, 0, 0);
        add_row(OP_LOAD,   2,  1,    1,   1, 0, 0, 0);
        add_row(OP_LOAD,   3,  8'h55, 1,  1, 0, 0, 0);
        add_row(OP_LOAD,   4,  8'hAA, 1,  1, 0, 0, 0);
        add_row(OP_LOAD,   5,  2,    1,   1, 0, 0, 0);
        add_row(OP_LOAD,   6,  254,  1,   1, 0, 0, 0);
        add_row(OP_LOAD,   7,  64,   1,   1, 0, 0, 0);
        add_row(OP_LOAD,   8,  192,  1,   1, 0, 0, 0);
        add_row(OP_LOAD,   9,  16,   1,   1, 0, 0, 0);
        add_row(OP_LOAD,   10, 240,  1,   1, 0, 0, 0);
        add_row(OP_LOAD,   11, 0,    1,   1, 0, 0, 0);
        add_row(OP_LOAD,   15, 8'hFF, 1,  1, 0, 0, 0);   // index out of range is ignored
        add_row(OP_LOAD,   12, 8'h33, 1,  1, 0, 0, 0);
        add_row(OP_COMMIT, 0,  0,    1,   1, 0, 1, 0);
        add_row(OP_COMMIT, 0,  0,    1,   1, 0, 0, 0);   // swap still due, so ignored
        add_row(OP_LOAD,   11, 255,  1,   1, 0, 0, 0);   // load while a swap is due
        add_row(OP_TICK,   0,  0,    63,  0, 0, 0, 0);   // one frame of ticks, swap inside
        add_row(OP_TICK,   9,  8'hC3, 4 * 63, 0, 0, 0, 0); // full dither cycle
        add_row(OP_COMMIT, 0,  0,    1,   0, 0, 0, 0);
        add_row(OP_TICK,   0,  0,    63,  0, 0, 0, 0);

        // Reset, released at a falling edge, away from the rising edge.
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        idle_rate = 2;
        foreach (stim_table[r])
        begin
            for (int n = 0; n < stim_table[r].count; n++)
            begin
                drive_item(stim_table[r].item, stim_table[r].typed, stim_table[r].want);
            end
        end

        // Random traffic, with the idling level changed every 64 commands.
        while (done_items < RANDOM_ITEMS)
        begin
            if (done_items % 64 == 0)
            begin
                idle_rate = $urandom_range(0, 3);
            end
            if (done_items >= RANDOM_ITEMS - 40)
            begin
                idle_rate = 0;
            end
            if (!hold_done && done_items >= RANDOM_ITEMS / 3)
            begin
                // Result side holds off while commands keep coming.
                hold_req  = 1'b1;
                hold_done = 1'b1;
            end
            if (!pause_done && done_items >= (2 * RANDOM_ITEMS) / 3)
            begin
                // Command side waits for every outstanding result.
                cmd_valid <= 1'b0;
                while (pending_results.size() != 0)
                begin
                    @(posedge clk);
                end
                @(negedge clk);
                pause_done = 1'b1;
            end
            item = random_item();
            drive_item(item, 1'b0, none);
            done_items++;
        end
        cmd_valid <= 1'b0;

        // Drain, then watch for any stray result before the verdict.
        while (pending_results.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (8) @(posedge clk);
        if (err_count == 0)
        begin
            $display("tb: success");
        end
        else
        begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

FILE: bam_led_dimmer_with_dither_top.f
hdl/bamd_pkg.sv
hdl/bamd_in_stage.sv
hdl/bamd_engine.sv
hdl/bam_led_dimmer_with_dither_top.sv
hdl/bamd_checker.sv
verif/bam_led_dimmer_with_dither_top_tb.sv
